@@ src/pc1_128_stream_encrypt_assert.svh @@
// Assertion macros for the PC1-128 checker file.
`ifndef PC1_128_STREAM_ENCRYPT_ASSERT_SVH
`define PC1_128_STREAM_ENCRYPT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PC1_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pc1 assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PC1_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pc1 assertion failed");

`endif

@@ src/pc1_pkg.sv @@
// Types and constants of the PC1-128 stream encryptor.
package pc1_pkg;

  localparam int unsigned KEY_REG_W  = 64;
  localparam int unsigned KEY_W      = 2 * KEY_REG_W;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned ROUND_W    = 3;

  localparam logic [WORD_W-1:0]    MUL_SEED   = 16'h015A;
  localparam logic [WORD_W-1:0]    MUL_CHAIN  = 16'h4E35;
  localparam logic [ROUND_W-1:0]   ROUND_LAST = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 8'd1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       restart;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } out_item_t;

  // Operands of one keystream round
  typedef struct packed {
    logic [WORD_W-1:0]  prev;
    logic [WORD_W-1:0]  kw;
    logic [WORD_W-1:0]  seed;
    logic [WORD_W-1:0]  chain;
    logic [WORD_W-1:0]  acc;
    logic [ROUND_W-1:0] idx;
  } round_in_t;

  // Updated chaining state after one round
  typedef struct packed {
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] chain;
    logic [WORD_W-1:0] acc;
  } round_out_t;

endpackage

@@ src/pc1_if.sv @@
// Valid/ready channel interfaces for input items, result items and configuration.
interface pc1_in_if;
  import pc1_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pc1_out_if;
  import pc1_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pc1_cfg_if;
  import pc1_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [KEY_REG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/pc1_round.sv @@
// One PC1-128 keystream round: constant multiplies, adds and accumulator fold.
module pc1_round (
  input  pc1_pkg::round_in_t  rnd_i,
  output pc1_pkg::round_out_t rnd_o
);
  import pc1_pkg::*;

  logic [WORD_W-1:0]   w;
  logic [WORD_W-1:0]   step;
  logic [2*WORD_W-1:0] prod_ws;
  logic [2*WORD_W-1:0] prod_wc;
  logic [2*WORD_W-1:0] prod_sc;
  logic [WORD_W-1:0]   chain_new;
  logic [WORD_W-1:0]   nxt;

  // Mix the previous round output into this key word
  assign w    = rnd_i.prev ^ rnd_i.kw;
  assign step = rnd_i.chain + {{(WORD_W-ROUND_W){1'b0}}, rnd_i.idx};

  // Products, kept modulo 2^16
  assign prod_ws = {{WORD_W{1'b0}}, w} * {{WORD_W{1'b0}}, MUL_SEED};
  assign prod_wc = {{WORD_W{1'b0}}, w} * {{WORD_W{1'b0}}, MUL_CHAIN};
  assign prod_sc = {{WORD_W{1'b0}}, step} * {{WORD_W{1'b0}}, MUL_CHAIN};

  assign chain_new = prod_sc[WORD_W-1:0] + prod_ws[WORD_W-1:0] + rnd_i.seed;
  assign nxt       = prod_wc[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, 1'b1};

  assign rnd_o.seed  = prod_ws[WORD_W-1:0];
  assign rnd_o.chain = chain_new;
  assign rnd_o.prev  = nxt;
  assign rnd_o.acc   = rnd_i.acc ^ nxt ^ chain_new;

endmodule

@@ src/pc1_128_stream_encrypt.sv @@
// PC1-128 byte stream encryptor: round sequencer, working key and result register.
// Each byte takes eight rounds on the single shared round unit, one round a cycle, but the last
// round is held while the result register is still full; no new item is taken before then,
// and the input is ready again on the cycle after the last round.
// A pending result is held in its own register while the next item is taken.
// Reset clears the key registers, working key and chaining words to zero, no wait.
module pc1_128_stream_encrypt (
  input  logic            clk_i,
  input  logic            rst_ni,
  pc1_cfg_if.sink         cfg_i,
  pc1_in_if.sink          in_i,
  pc1_out_if.source       out_o
);
  import pc1_pkg::*;

  state_e               state_q, state_d;
  logic [KEY_REG_W-1:0] key_upper_q, key_lower_q;
  logic [KEY_W-1:0]     wk_q;
  logic [KEY_W-1:0]     wk_rot;
  logic [WORD_W-1:0]    seed_q, chain_q, prev_q, acc_q;
  logic [ROUND_W-1:0]   cnt_q;
  logic [7:0]           plain_q;
  logic                 last_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  logic       accept;
  logic       step_en;
  logic       finish;
  round_in_t  rnd_in;
  round_out_t rnd_out;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KEY_UPPER: key_upper_q <= cfg_i.data;
        REG_KEY_LOWER: key_lower_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;

  // Sequencer: hold the last round until the result register is free
  always_comb begin
    state_d = state_q;
    step_en = 1'b0;
    finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RUN;
      end
      ST_RUN: begin
        step_en = (cnt_q != ROUND_LAST) || !out_valid_q || out_o.ready;
        finish  = step_en && (cnt_q == ROUND_LAST);
        if (finish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Shared round unit, current key word at the top of the rotating key
  assign rnd_in.prev  = prev_q;
  assign rnd_in.kw    = wk_q[KEY_W-1 -: WORD_W];
  assign rnd_in.seed  = seed_q;
  assign rnd_in.chain = chain_q;
  assign rnd_in.acc   = acc_q;
  assign rnd_in.idx   = cnt_q;

  pc1_round u_round (
    .rnd_i (rnd_in),
    .rnd_o (rnd_out)
  );

  assign wk_rot = {wk_q[KEY_W-WORD_W-1:0], wk_q[KEY_W-1 -: WORD_W]};

  // Advance the cipher state one round a cycle while the sequencer steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_q    <= '0;
      seed_q  <= '0;
      chain_q <= '0;
      prev_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      cnt_q  <= '0;
      prev_q <= '0;
      acc_q  <= '0;
      if (in_i.item.restart) begin
        wk_q    <= {key_upper_q, key_lower_q};
        seed_q  <= '0;
        chain_q <= '0;
      end
    end else if (step_en) begin
      cnt_q   <= cnt_q + 1'b1;
      prev_q  <= rnd_out.prev;
      acc_q   <= rnd_out.acc;
      seed_q  <= rnd_out.seed;
      chain_q <= rnd_out.chain;
      // after the eighth rotation the key is back in place: fold in the plaintext
      wk_q    <= finish ? (wk_rot ^ {(KEY_W/8){plain_q}}) : wk_rot;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      plain_q <= in_i.item.plain_byte;
      last_q  <= in_i.item.last_in;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (finish)      out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_item_q.cipher_byte <= plain_q ^ rnd_out.acc[15:8] ^ rnd_out.acc[7:0];
      out_item_q.last_out    <= last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule

@@ src/pc1_128_stream_encrypt_chk.sv @@
// Port-level checker for the PC1-128 stream encryptor and its bind.
`include "pc1_128_stream_encrypt_assert.svh"

module pc1_128_stream_encrypt_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input pc1_pkg::out_item_t out_item_i
);
  import pc1_pkg::*;

  // A result waiting to be taken holds
  `PC1_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i))

  // An accepted item closes the input for the round sequence
  `PC1_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // No new item before all eight rounds have run
  `PC1_ASSERT_IMP(a_eight_rounds, in_valid_i && in_ready_i, ##8 !in_ready_i)

  // A fresh result only appears out of a busy cycle
  `PC1_ASSERT_IMP(a_result_from_run, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind pc1_128_stream_encrypt pc1_128_stream_encrypt_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);

@@ tb/pc1_128_stream_encrypt_tb.sv @@
// Self-checking testbench of the PC1-128 stream encryptor: predicts every cipher byte and checks it.
module pc1_128_stream_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pc1_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 500_000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned KEY_BYTES = 16;
  localparam int unsigned ROUNDS = 8;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 160;

  // Indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_UNMAPPED   = 8'hFF;

  typedef enum int {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pc1_in_if  in_if ();
  pc1_out_if out_if ();
  pc1_cfg_if cfg_if ();

  pc1_128_stream_encrypt u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Own copy of the cipher state
  logic [KEY_REG_W-1:0] key_hi = '0;
  logic [KEY_REG_W-1:0] key_lo = '0;
  logic [7:0]           work_key [KEY_BYTES];
  logic [WORD_W-1:0]    seed_w = '0;
  logic [WORD_W-1:0]    chain_w = '0;

  out_item_t pending_cipher_q [$];

  int unsigned fail_count = 0;
  int unsigned items_taken = 0;
  int unsigned restarts_taken = 0;
  int unsigned results_checked = 0;
  int unsigned key_writes = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_len = 0;
  sink_mode_e  sink_mode = SINK_ALWAYS;
  logic        hold_active = 1'b0;
  logic [6:0]  ready_pattern = 7'b1011001;
  event        hold_go;

  initial begin
    for (int k = 0; k < KEY_BYTES; k++) work_key[k] = 8'h00;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run the eight keystream rounds and fold the plaintext into the working key
  function automatic out_item_t encrypt_byte(in_item_t it);
    logic [KEY_W-1:0]  full_key;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] kw;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] old_seed;
    logic [WORD_W-1:0] step;
    logic [WORD_W-1:0] nxt;
    logic [7:0]        ks;
    out_item_t         res;
    full_key = {key_hi, key_lo};
    if (it.restart) begin
      for (int k = 0; k < KEY_BYTES; k++) work_key[k] = full_key[8*(KEY_BYTES-1-k) +: 8];
      seed_w = '0;
      chain_w = '0;
    end
    acc = '0;
    prev = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      kw = {work_key[2*r], work_key[2*r+1]};
      w = prev ^ kw;
      old_seed = seed_w;
      step = chain_w + 16'(r);
      seed_w = w * MUL_SEED;
      chain_w = step * MUL_CHAIN + w * MUL_SEED + old_seed;
      nxt = w * MUL_CHAIN + 16'd1;
      prev = nxt;
      acc = acc ^ nxt ^ chain_w;
    end
    ks = acc[15:8] ^ acc[7:0];
    for (int k = 0; k < KEY_BYTES; k++) work_key[k] = work_key[k] ^ it.plain_byte;
    res.cipher_byte = it.plain_byte ^ ks;
    res.last_out = it.last_in;
    return res;
  endfunction

  // Track key writes and accepted items, check every result against the oldest prediction
  always @(posedge clk_i) begin : track_items
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        key_writes++;
        if (cfg_if.index == REG_KEY_UPPER) key_hi = cfg_if.data;
        else if (cfg_if.index == REG_KEY_LOWER) key_lo = cfg_if.data;
      end
      if (in_if.valid && !in_if.ready) input_stall_cycles++;
      if (in_if.valid && in_if.ready) begin
        pending_cipher_q.push_back(encrypt_byte(in_if.item));
        items_taken++;
        if (in_if.item.restart) restarts_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.item;
        if (pending_cipher_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cipher_byte %02h last_out %0b",
                   $time, got.cipher_byte, got.last_out);
          fail_count++;
        end else begin
          want = pending_cipher_q.pop_front();
          results_checked++;
          if (got.cipher_byte !== want.cipher_byte) begin
            $display("%0t: cipher_byte mismatch, expected %02h, actual %02h",
                     $time, want.cipher_byte, got.cipher_byte);
            fail_count++;
          end
          if (got.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch, expected %0b, actual %0b",
                     $time, want.last_out, got.last_out);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: stall on its own pattern, or hold off entirely during a hold
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      ready_pattern <= {ready_pattern[0], ready_pattern[6:1]};
      if (!rst_ni || hold_active) begin
        out_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_RANDOM:  out_if.ready <= ($urandom_range(0, 99) < 60);
          SINK_PATTERN: out_if.ready <= ready_pattern[0];
          default:      out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Long hold-off of the receiver, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (hold_len) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_cipher_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item and hold it until taken; valid stays high for a following item
  task automatic send_byte(input in_item_t it);
    in_if.item <= it;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_plain(input logic [7:0] p, input logic restart, input logic last);
    in_item_t it;
    it.plain_byte = p;
    it.restart = restart;
    it.last_in = last;
    send_byte(it);
  endtask

  task automatic pause_input(input int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Send in bursts of random length with random gaps in between
  task automatic send_paced(input in_item_t it, input bit gaps_on);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      pause_input($urandom_range(1, 6));
    end
    send_byte(it);
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid, let the last accepted item reach the queue, then wait for every result
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cipher_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_REG_W-1:0] data);
    cfg_if.index <= idx;
    cfg_if.data <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [KEY_REG_W-1:0] pick_key(input int unsigned sel);
    case (sel % 5)
      1:       return '0;
      2:       return '1;
      3:       return 64'hA5A5_5A5A_C3C3_3C3C;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Stream from the all-zero reset key, never restarted
  task automatic test_reset_key();
    send_plain(8'h00, 1'b0, 1'b0);
    send_plain(8'hFF, 1'b0, 1'b1);
    send_plain(8'h80, 1'b0, 1'b0);
    send_plain(8'h01, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Key writes take effect only on restart; unmapped indexes are ignored
  task automatic test_key_registers();
    write_key(REG_KEY_UPPER, '1);
    write_key(REG_KEY_LOWER, '0);
    send_plain(8'h3C, 1'b0, 1'b0);
    send_plain(8'hC3, 1'b0, 1'b1);
    send_plain(8'hFF, 1'b1, 1'b0);
    send_plain(8'h00, 1'b0, 1'b1);
    wait_idle();
    write_key(REG_FIRST_UNMAPPED, {$urandom, $urandom});
    write_key(REG_TOP_UNMAPPED, '1);
    send_plain(8'h55, 1'b1, 1'b1);
    wait_idle();
    write_key(REG_KEY_UPPER, '0);
    write_key(REG_KEY_LOWER, '1);
    send_plain(8'hAA, 1'b1, 1'b0);
    send_plain(8'h7F, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Field extremes with every restart/last combination under a stalling receiver
  task automatic test_field_extremes();
    write_key(REG_KEY_UPPER, {$urandom, $urandom});
    write_key(REG_KEY_LOWER, {$urandom, $urandom});
    sink_mode = SINK_RANDOM;
    send_plain(8'h00, 1'b1, 1'b1);
    send_plain(8'hFF, 1'b1, 1'b1);
    send_plain(8'h01, 1'b1, 1'b0);
    send_plain(8'h80, 1'b1, 1'b0);
    send_plain(8'hFE, 1'b0, 1'b0);
    send_plain(8'h7F, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Hold the receiver off while items keep coming so the block backs up
  task automatic test_backpressure();
    sink_mode = SINK_ALWAYS;
    hold_len = HOLD_OFF_CYCLES;
    -> hold_go;
    for (int n = 0; n < 20; n++) send_plain(8'($urandom), n == 0, n == 19);
    wait_idle();
  endtask

  // Random messages over several key settings and idling styles
  task automatic test_random_stream();
    in_item_t    it;
    int unsigned sent;
    int unsigned len;
    bit          gaps_on;
    bit          broken;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_key(REG_KEY_UPPER, pick_key(phase));
      write_key(REG_KEY_LOWER, pick_key(phase + 3));
      sink_mode = sink_mode_e'(phase % 3);
      // one phase runs with neither side idling
      gaps_on = (phase != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        broken = ($urandom_range(0, 19) == 0);
        for (int b = 0; b < len; b++) begin
          it.plain_byte = 8'($urandom);
          it.restart = (b == 0) ? !broken : ($urandom_range(0, 24) == 0);
          it.last_in = (b == len - 1) ? !broken : ($urandom_range(0, 24) == 0);
          send_paced(it, gaps_on);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.item <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_registers();
    test_field_extremes();
    test_backpressure();
    test_random_stream();
    wait_idle();

    $display("Encrypted %0d bytes (%0d restarts) over %0d key writes, %0d results checked.",
             items_taken, restarts_taken, key_writes, results_checked);
    $display("Input held back for %0d cycles while the rounds ran or the receiver stalled.",
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pc1_pkg.sv
src/pc1_if.sv
src/pc1_round.sv
src/pc1_128_stream_encrypt.sv
src/pc1_128_stream_encrypt_chk.sv
tb/pc1_128_stream_encrypt_tb.sv
